### sv/mpow_pkg.sv
// shared types and constants for the modular power block
package mpow_pkg;

    localparam int WORD_BITS = 64;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    // operation codes of the shared modular unit
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_RED = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;

    // request from the sequencer to the modular unit
    typedef struct packed {
        logic  start;
        logic  op;
        t_word x;
        t_word y;
        t_word n;
    } t_mm_req;

endpackage

### sv/mpow_mulmod.sv
// shared bit-serial modular multiply and reduce unit
module mpow_mulmod
    import mpow_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_mm_req i_req,
    output logic    o_busy,
    output logic    o_done,
    output t_word   o_res
);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic                r_op, r_ph, n_ph;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    t_word               r_x, r_y, n_y, r_n, r_acc, n_acc;

    logic [WORD_BITS:0]  w_s;
    logic [WORD_BITS:0]  w_r;
    logic                w_bit;

    assign w_bit = r_y[WORD_BITS-1];

    // one add, one compare and subtract against the modulus
    always_comb begin
        w_s = {1'b0, r_acc}
            + ((r_op == OP_MUL && r_ph) ? {1'b0, r_x} : {1'b0, r_acc})
            + {{WORD_BITS{1'b0}}, (r_op == OP_RED) & w_bit};
        w_r = (w_s >= {1'b0, r_n}) ? (w_s - {1'b0, r_n}) : w_s;
    end

    // step sequencing over the bits of y, msb first
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_ph   = r_ph;
        n_cnt  = r_cnt;
        n_y    = r_y;
        n_acc  = r_acc;
        if (r_busy) begin
            n_acc = w_r[WORD_BITS-1:0];
            if (r_op == OP_MUL && !r_ph && w_bit) begin
                n_ph = 1'b1;
            end else begin
                n_ph = 1'b0;
                n_y  = {r_y[WORD_BITS-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_req.start ? 1'b1 : n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_x   <= i_req.x;
            r_y   <= i_req.y;
            r_n   <= i_req.n;
            r_acc <= '0;
            r_ph  <= 1'b0;
            r_cnt <= CNT_BITS'(WORD_BITS - 1);
        end else begin
            r_y   <= n_y;
            r_acc <= n_acc;
            r_ph  <= n_ph;
            r_cnt <= n_cnt;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_res  = r_acc;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start) else $error("start while busy");
    a_res_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_n != '0) |-> (r_acc < r_n)) else $error("result not reduced");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without work");
`endif

endmodule

### sv/modular_power.sv
// top level: exponent sequencer around the shared modular unit
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// The base is first reduced by one pass of the shared unit; each
// modular multiply then runs one doubling step per multiplier bit plus
// one add step per set bit, all through the one shared add/compare unit.
// The input is not ready while an item is in work. A result waits in the
// output register while the next item is accepted.
module modular_power
    import mpow_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [63:0]  i_cfg_data,     // modulus
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,      // [63:0] base, [127:64] exponent
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata       // [63:0] power
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_MULA = 3'd3;
    localparam logic [2:0] ST_SHFT = 3'd4;
    localparam logic [2:0] ST_MULS = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0] r_state, n_state;
    t_word      r_mod, r_n, r_e, r_acc, r_sq, r_out;
    logic       r_ovalid;
    t_mm_req    w_req;
    logic       w_busy, w_done;
    t_word      w_res;
    logic       w_in_xfer, w_out_xfer, w_load;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign w_in_xfer   = i_s_tvalid && o_s_tready;
    assign w_out_xfer  = r_ovalid && i_m_tready;
    assign w_load      = (r_state == ST_DONE) && (!r_ovalid || i_m_tready);

    mpow_mulmod u_mm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // sequencer next state and unit requests
    always_comb begin
        n_state     = r_state;
        w_req.start = 1'b0;
        w_req.op    = OP_MUL;
        w_req.x     = r_acc;
        w_req.y     = r_sq;
        w_req.n     = r_n;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (r_mod[WORD_BITS-1:0] == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        w_req.start = 1'b1;
                        w_req.op    = OP_RED;
                        w_req.y     = i_s_tdata[WORD_BITS-1:0];
                        w_req.n     = r_mod[WORD_BITS-1:0];
                        n_state     = ST_RED;
                    end
                end
            end
            ST_RED: begin
                if (w_done) n_state = ST_CHK;
            end
            ST_CHK: begin
                if (r_e == '0) begin
                    n_state = ST_DONE;
                end else if (r_e[0]) begin
                    w_req.start = 1'b1;
                    n_state     = ST_MULA;
                end else begin
                    n_state = ST_SHFT;
                end
            end
            ST_MULA: begin
                if (w_done) n_state = ST_SHFT;
            end
            ST_SHFT: begin
                if (r_e[WORD_BITS-1:1] != '0) begin
                    w_req.start = 1'b1;
                    w_req.x     = r_sq;
                    n_state     = ST_MULS;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MULS: begin
                if (w_done) n_state = ST_CHK;
            end
            ST_DONE: begin
                if (w_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_mod    <= 64'd1;
        end else begin
            r_state <= n_state;
            if (w_load)          r_ovalid <= 1'b1;
            else if (w_out_xfer) r_ovalid <= 1'b0;
            if (i_cfg_valid)     r_mod <= i_cfg_data;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_n   <= r_mod[WORD_BITS-1:0];
            r_e   <= i_s_tdata[64 +: WORD_BITS];
            r_acc <= '0;
        end
        if (r_state == ST_RED && w_done) begin
            r_sq  <= w_res;
            r_acc <= (r_n == t_word'(1)) ? '0 : t_word'(1);
        end
        if (r_state == ST_MULA && w_done) r_acc <= w_res;
        if (r_state == ST_MULS && w_done) r_sq <= w_res;
        if (r_state == ST_SHFT) r_e <= {1'b0, r_e[WORD_BITS-1:1]};
        if (w_load) r_out <= r_acc;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_out;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_s_tready) else $error("input ready while unit busy");
    a_out_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_n != '0) |-> (r_acc < r_n)) else $error("power not below modulus");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_RED || r_state == ST_MULA || r_state == ST_MULS))
        else $error("unit done outside a wait state");
`endif

endmodule

### test/tb_top.sv
// testbench for modular_power: random and directed items checked against a scoreboard
`timescale 1ns / 100ps

module tb_top;
    import mpow_pkg::*;

    // expected powers, worked out from each accepted base and exponent
    class power_board;
        t_word modulus;
        t_word want_q[$];

        function new();
            modulus = 64'd1;
        endfunction

        function t_word mul_mod(t_word a, t_word b);
            logic [127:0] prod;
            prod = a * b;
            return t_word'(prod % {64'd0, modulus});
        endfunction

        function t_word mod_pow(t_word base, t_word exponent);
            t_word run_sq;
            t_word acc;
            t_word e;
            if (modulus == 0) return '0;
            run_sq = base % modulus;
            acc    = (modulus == 1) ? t_word'(0) : t_word'(1);
            e      = exponent;
            while (e != 0) begin
                if (e[0]) acc = mul_mod(acc, run_sq);
                e = e >> 1;
                if (e != 0) run_sq = mul_mod(run_sq, run_sq);
            end
            return acc;
        endfunction

        function void note_item(t_word base, t_word exponent);
            want_q.push_back(mod_pow(base, exponent));
        endfunction

        // returns 1 on a mismatch; no_entry flags a result with nothing waiting
        function bit check_power(t_word got, output t_word want, output bit no_entry);
            no_entry = (want_q.size() == 0);
            want = '0;
            if (no_entry) return 1'b1;
            want = want_q.pop_front();
            return got != want;
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [63:0]  i_cfg_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [127:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [63:0]  o_m_tdata;

    power_board sb;
    int         n_errors;
    int         n_results;
    int         stall_left;
    bit         held_once;

    modular_power i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard limit on run length
    initial begin
        #40000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report(string what, t_word got, t_word want);
        n_errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // one transfer on the input stream
    task automatic send_item(t_word base, t_word exponent);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {exponent, base};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(base, exponent);
    endtask

    // wait for all results, then write the modulus
    task automatic write_modulus(t_word value);
        i_s_tvalid <= 1'b0;
        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.modulus = value;
    endtask

    function automatic t_word rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_word pick_modulus();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return 64'd1;
            2: return 64'd2;
            3: return t_word'($urandom_range(3, 1000));
            4: return 64'd1 << $urandom_range(1, 63);
            5: return (rand_word() >> 1) | (64'd1 << 63);
            6: return t_word'($urandom()) | 64'd1;
            default: return rand_word() | 64'd1;
        endcase
    endfunction

    // exponents are mostly short so that items finish quickly
    function automatic t_word pick_exponent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return rand_word();
        if (r < 60) return t_word'($urandom_range(0, 15));
        if (r < 90) return t_word'($urandom_range(0, 255));
        return t_word'($urandom_range(0, 65535));
    endfunction

    function automatic t_word pick_base(t_word m);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return m;
            2: return m - 1;
            3: return t_word'($urandom_range(0, 20));
            default: return rand_word();
        endcase
    endfunction

    // result side with random stalls and one long hold-off
    initial begin
        i_m_tready = 1'b0;
        stall_left = 0;
        held_once  = 1'b0;
        n_results  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                t_word want;
                bit    no_entry;
                n_results++;
                if (sb.check_power(o_m_tdata, want, no_entry)) begin
                    if (no_entry) report("unexpected result", o_m_tdata, '0);
                    else report("power", o_m_tdata, want);
                end
            end
            if (n_results == 300 && !held_once) begin
                held_once  = 1'b1;
                stall_left = 5000;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_left = pick_gap();
            end
            i_m_tready <= i_rst_n && (stall_left == 0);
        end
    end

    // stimulus
    initial begin
        t_word m;
        sb          = new();
        n_errors    = 0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // modulus one after reset: always zero
        send_item('1, '1);
        send_item(64'd5, '0);
        send_item('0, '0);

        // largest modulus: field extremes and base at or above the modulus
        write_modulus('1);
        send_item('0, '0);
        send_item('0, 64'd1);
        send_item('1, 64'd1);
        send_item('1, 64'd2);
        send_item('1 - 1, '1);
        send_item(64'd2, 64'd63);
        send_item(64'd2, 64'd64);
        send_item(64'd3, '1);
        send_item(rand_word(), 64'd0);

        // small modulus: bases from below to well above it
        write_modulus(64'd97);
        send_item('1, 64'd96);
        send_item(64'd97, 64'd3);
        send_item(64'd98, '1);
        send_item(64'd5, '0);

        // modulus two and top bit set
        write_modulus(64'd2);
        send_item('1, 64'd7);
        send_item(64'd2, '0);
        write_modulus(64'h8000_0000_0000_0001);
        send_item('1, 64'h8000_0000_0000_0000);
        send_item(64'h8000_0000_0000_0000, 64'd2);

        // random phases, each under its own modulus
        for (int ph = 0; ph < 9; ph++) begin
            m = (ph == 8) ? t_word'(1) : pick_modulus();
            write_modulus(m);
            for (int k = 0; k < 100; k++) send_item(pick_base(m), pick_exponent());
        end

        i_s_tvalid <= 1'b0;
        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && sb.want_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
